// File: hdl/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants of the particle contact resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

	// fixed field widths
	localparam int TS_W     = 21;
	localparam int BOUNCE_W = 17;
	localparam int IM_W     = 31;
	localparam logic [TS_W-1:0] TS_RESET = 21'd1092;

	// divider: 31 quotient bits, one per step, plus an entry stage
	localparam int QUO_W     = 31;
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_LAT   = DIV_STEPS + 1;

	// queues
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	// packed vector: x low, y high
	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vec_t;

	// one contact as it arrives
	typedef struct packed {
		vec_t                n;
		vec_t                v0;
		vec_t                v1;
		vec_t                a0;
		vec_t                a1;
		vec_t                p0;
		vec_t                p1;
		logic [IM_W-1:0]     im0;
		logic [IM_W-1:0]     im1;
		logic signed [31:0]  pen;
		logic                two;
		logic [BOUNCE_W-1:0] bounce;
	} contact_t;

	// fields that ride along the whole datapath
	typedef struct packed {
		vec_t               n;
		vec_t               v0;
		vec_t               v1;
		vec_t               p0;
		vec_t               p1;
		logic [IM_W-1:0]    im0;
		logic [IM_W-1:0]    im1;
		logic [31:0]        total;
		logic signed [31:0] pen;
	} base_t;

	// classified contact handed from front to back
	typedef struct packed {
		base_t       base;
		logic [31:0] dv;
		logic        do_vel;
		logic        do_pos;
	} job_t;

	// one result item
	typedef struct packed {
		vec_t v0;
		vec_t v1;
		vec_t p0;
		vec_t p1;
	} result_t;

	// queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > S32_MAX) begin
			return 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/pcr_fifo.sv
// ----------------------------------------------------------------------------
// pcr_fifo
// Small register queue, four entries, with full/empty status.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_fifo import pcr_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output q_stat_t      stat
);

	logic [W-1:0]       mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;

	// storage; the writer must write only when not full, the block itself does not enforce it
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(wr) - (FIFO_AW+1)'(rd);
		end
	end

	assign rdata      = mem_q[rp_q];
	assign stat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

// File: hdl/pcr_front.sv
// ----------------------------------------------------------------------------
// pcr_front
// Front pipeline: relative motion, separating velocity, target velocity and
// the velocity change; classifies each contact into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_front import pcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [TS_W-1:0] time_step,
	input  logic            push,
	input  contact_t        ct,
	input  q_stat_t         mid_stat,
	output logic            job_push,
	output job_t            job
);

	logic en;

	logic [IM_W-1:0] im1_in;
	base_t           base_in;
	vec_t            rv_in;
	vec_t            ra_in;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	base_t               base_s1, base_s2, base_s3, base_s4, base_s5, base_s6;
	logic [BOUNCE_W-1:0] bounce_s1, bounce_s2, bounce_s3, bounce_s4, bounce_s5;
	vec_t                rv_s1, ra_s1;
	logic signed [63:0]  prx_s2, pry_s2, pax_s2, pay_s2;
	logic signed [31:0]  sep_s3, acc_s3;
	logic signed [31:0]  sep_s4, sep_s5, sep_s6;
	logic signed [53:0]  accts_s4;
	logic signed [50:0]  nsb_s4;
	logic signed [31:0]  accsep_s5, tgt0_s5, tgt0_s6;
	logic signed [49:0]  bprod_s6;
	logic                accneg_s6;

	logic signed [50:0] sum;
	logic signed [31:0] tgt;
	logic signed [32:0] dv;
	logic               nz;

	assign en = !mid_stat.full;

	// entry: relative vectors and total inverse mass
	always_comb begin
		im1_in        = ct.two ? ct.im1 : '0;
		base_in.n     = ct.n;
		base_in.v0    = ct.v0;
		base_in.v1    = ct.v1;
		base_in.p0    = ct.p0;
		base_in.p1    = ct.p1;
		base_in.im0   = ct.im0;
		base_in.im1   = im1_in;
		base_in.total = 32'(ct.im0) + 32'(im1_in);
		base_in.pen   = ct.pen;
		rv_in.x = ct.two ? sat32(64'(ct.v0.x) - 64'(ct.v1.x)) : ct.v0.x;
		rv_in.y = ct.two ? sat32(64'(ct.v0.y) - 64'(ct.v1.y)) : ct.v0.y;
		ra_in.x = ct.two ? sat32(64'(ct.a0.x) - 64'(ct.a1.x)) : ct.a0.x;
		ra_in.y = ct.two ? sat32(64'(ct.a0.y) - 64'(ct.a1.y)) : ct.a0.y;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: captured item
			base_s1   <= base_in;
			bounce_s1 <= ct.bounce;
			rv_s1     <= rv_in;
			ra_s1     <= ra_in;
			// s2: dot product terms
			base_s2   <= base_s1;
			bounce_s2 <= bounce_s1;
			prx_s2    <= rv_s1.x * base_s1.n.x;
			pry_s2    <= rv_s1.y * base_s1.n.y;
			pax_s2    <= ra_s1.x * base_s1.n.x;
			pay_s2    <= ra_s1.y * base_s1.n.y;
			// s3: separating velocity and normal acceleration
			base_s3   <= base_s2;
			bounce_s3 <= bounce_s2;
			sep_s3    <= sat32((prx_s2 >>> FRAC_BITS) + (pry_s2 >>> FRAC_BITS));
			acc_s3    <= sat32((pax_s2 >>> FRAC_BITS) + (pay_s2 >>> FRAC_BITS));
			// s4: acceleration over dt, restitution of closing speed
			base_s4   <= base_s3;
			bounce_s4 <= bounce_s3;
			sep_s4    <= sep_s3;
			accts_s4  <= acc_s3 * $signed({1'b0, time_step});
			nsb_s4    <= -(33'(sep_s3)) * $signed({1'b0, bounce_s3});
			// s5: scaled values
			base_s5   <= base_s4;
			bounce_s5 <= bounce_s4;
			sep_s5    <= sep_s4;
			accsep_s5 <= sat32(64'(accts_s4 >>> FRAC_BITS));
			tgt0_s5   <= sat32(64'(nsb_s4 >>> FRAC_BITS));
			// s6: restitution of built-up acceleration
			base_s6   <= base_s5;
			sep_s6    <= sep_s5;
			tgt0_s6   <= tgt0_s5;
			bprod_s6  <= $signed({1'b0, bounce_s5}) * accsep_s5;
			accneg_s6 <= accsep_s5[31];
		end
	end

	// target clamp, velocity change and classification
	always_comb begin
		sum = 51'(tgt0_s6) + 51'(bprod_s6 >>> FRAC_BITS);
		if (accneg_s6) begin
			tgt = sum[50] ? 32'sd0 : sum[31:0];
		end else begin
			tgt = tgt0_s6;
		end
		dv         = 33'(tgt) - 33'(sep_s6);
		nz         = (base_s6.total != '0);
		job.base   = base_s6;
		job.dv     = dv[31:0];
		job.do_vel = nz && (sep_s6[31] || (sep_s6 == 32'sd0));
		job.do_pos = nz && !base_s6.pen[31] && (base_s6.pen != 32'sd0);
	end

	assign job_push = en && vld_s6;

endmodule

`default_nettype wire

// File: hdl/pcr_div.sv
// ----------------------------------------------------------------------------
// pcr_div
// Pipelined restoring divider: (dividend << FRAC_BITS) / divisor, one
// quotient bit per stage, quotient saturated to 2^31-1.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_div import pcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [31:0]      dividend,
	input  logic [31:0]      divisor,
	output logic [QUO_W-1:0] quo
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int HW = NW - QUO_W;

	logic [NW-1:0] num;
	logic [HW-1:0] hi;

	logic [31:0]      rem_s [0:DIV_STEPS-1];
	logic [QUO_W-1:0] low_s [0:DIV_STEPS-1];
	logic [31:0]      den_s [0:DIV_STEPS-1];
	logic [QUO_W-1:0] quo_s [0:DIV_STEPS];
	logic             ovf_s [0:DIV_STEPS];

	assign num = {dividend, {FRAC_BITS{1'b0}}};
	assign hi  = num[NW-1:QUO_W];

	// entry: bits above the quotient decide saturation
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 32'(hi);
			low_s[0] <= num[QUO_W-1:0];
			den_s[0] <= divisor;
			ovf_s[0] <= (32'(hi) >= divisor);
			quo_s[0] <= '0;
		end
	end

	// one compare/subtract per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;

		assign t    = {rem_s[k-1], low_s[k-1][QUO_W-1]};
		assign diff = t - {1'b0, den_s[k-1]};
		assign ge   = (t >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < DIV_STEPS) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[31:0] : t[31:0];
					low_s[k] <= {low_s[k-1][QUO_W-2:0], 1'b0};
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = ovf_s[DIV_STEPS] ? '1 : quo_s[DIV_STEPS];

endmodule

`default_nettype wire

// File: hdl/pcr_back.sv
// ----------------------------------------------------------------------------
// pcr_back
// Back pipeline: impulse and move per inverse mass, distribution to both
// particles and final selection of the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_back import pcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  q_stat_t mid_stat,
	output logic    mid_pop,
	input  q_stat_t out_stat,
	output logic    res_push,
	output result_t res
);

	logic en;

	logic [QUO_W-1:0] imp;
	logic [QUO_W-1:0] mv;

	job_t               dly_s [DIV_LAT];
	logic [DIV_LAT-1:0] dly_vld_s;
	job_t               job_d;

	logic               vld_s1, vld_s2, vld_s3;
	job_t               job_s1, job_s2, job_s3;
	logic signed [63:0] pix_s1, piy_s1, pmx_s1, pmy_s1;
	logic signed [31:0] ix_s2, iy_s2, mx_s2, my_s2;
	logic signed [63:0] vi0x_s3, vi0y_s3, vi1x_s3, vi1y_s3;
	logic signed [63:0] pm0x_s3, pm0y_s3, pm1x_s3, pm1y_s3;

	assign en      = !out_stat.full;
	assign mid_pop = en && !mid_stat.empty;

	// impulse per inverse mass and move per inverse mass
	pcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_vel (
		.clk      (clk),
		.en       (en),
		.dividend (job.dv),
		.divisor  (job.base.total),
		.quo      (imp)
	);

	pcr_div #(.FRAC_BITS(FRAC_BITS)) u_div_pos (
		.clk      (clk),
		.en       (en),
		.dividend ($unsigned(job.base.pen)),
		.divisor  (job.base.total),
		.quo      (mv)
	);

	// job delay line matched to divider latency
	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= job;
			for (int k = 1; k < DIV_LAT; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign job_d = dly_s[DIV_LAT-1];

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_vld_s <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
		end else if (en) begin
			dly_vld_s <= {dly_vld_s[DIV_LAT-2:0], !mid_stat.empty};
			vld_s1    <= dly_vld_s[DIV_LAT-1];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: scale normal by per-mass quotients
			job_s1  <= job_d;
			pix_s1  <= job_d.base.n.x * $signed({1'b0, imp});
			piy_s1  <= job_d.base.n.y * $signed({1'b0, imp});
			pmx_s1  <= job_d.base.n.x * $signed({1'b0, mv});
			pmy_s1  <= job_d.base.n.y * $signed({1'b0, mv});
			// s2: impulse and move vectors
			job_s2  <= job_s1;
			ix_s2   <= sat32(pix_s1 >>> FRAC_BITS);
			iy_s2   <= sat32(piy_s1 >>> FRAC_BITS);
			mx_s2   <= sat32(pmx_s1 >>> FRAC_BITS);
			my_s2   <= sat32(pmy_s1 >>> FRAC_BITS);
			// s3: share by inverse mass
			job_s3  <= job_s2;
			vi0x_s3 <= ix_s2 * $signed({1'b0, job_s2.base.im0});
			vi0y_s3 <= iy_s2 * $signed({1'b0, job_s2.base.im0});
			vi1x_s3 <= ix_s2 * $signed({1'b0, job_s2.base.im1});
			vi1y_s3 <= iy_s2 * $signed({1'b0, job_s2.base.im1});
			pm0x_s3 <= mx_s2 * $signed({1'b0, job_s2.base.im0});
			pm0y_s3 <= my_s2 * $signed({1'b0, job_s2.base.im0});
			pm1x_s3 <= mx_s2 * $signed({1'b0, job_s2.base.im1});
			pm1y_s3 <= my_s2 * $signed({1'b0, job_s2.base.im1});
		end
	end

	// apply and select; second particle gets zero share when absent
	always_comb begin
		res = {job_s3.base.v0, job_s3.base.v1, job_s3.base.p0, job_s3.base.p1};
		if (job_s3.do_vel) begin
			res.v0.x = sat32(64'(job_s3.base.v0.x) + (vi0x_s3 >>> FRAC_BITS));
			res.v0.y = sat32(64'(job_s3.base.v0.y) + (vi0y_s3 >>> FRAC_BITS));
			res.v1.x = sat32(64'(job_s3.base.v1.x) - (vi1x_s3 >>> FRAC_BITS));
			res.v1.y = sat32(64'(job_s3.base.v1.y) - (vi1y_s3 >>> FRAC_BITS));
		end
		if (job_s3.do_pos) begin
			res.p0.x = sat32(64'(job_s3.base.p0.x) + (pm0x_s3 >>> FRAC_BITS));
			res.p0.y = sat32(64'(job_s3.base.p0.y) + (pm0y_s3 >>> FRAC_BITS));
			res.p1.x = sat32(64'(job_s3.base.p1.x) - (pm1x_s3 >>> FRAC_BITS));
			res.p1.y = sat32(64'(job_s3.base.p1.y) - (pm1y_s3 >>> FRAC_BITS));
		end
	end

	assign res_push = en && vld_s3;

endmodule

`default_nettype wire

// File: hdl/particle_contact_resolver.sv
// ----------------------------------------------------------------------------
// particle_contact_resolver
// Resolves one 2D particle contact per item: impulse on the velocities and
// removal of interpenetration on the positions.
//
// Input side is a queue write port: an item is taken on a clock edge with
// push high and full low. Result side is a queue read port: the oldest result
// sits on the new_* ports while empty is low and leaves on an edge with pop
// high. cfg_we/cfg_wdata write the time step; write it only when idle.
// Throughput is one item per cycle while full stays low. An accepted item
// passes six front stages, the 32-stage restoring divider in the back end,
// and three multiply/saturate stages before it enters the output queue.
// A four-entry queue sits between front and back and another at the output.
// When the receiver stops popping, the output queue fills, the back end
// freezes, the middle queue fills and full rises; nothing is dropped.
// Reset empties both queues, clears all valids and loads time step 1092.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_contact_resolver import pcr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [TS_W-1:0]     cfg_wdata,
	input  logic                push,
	output logic                full,
	input  logic [63:0]         contact_normal,
	input  logic [63:0]         first_velocity,
	input  logic [63:0]         second_velocity,
	input  logic [63:0]         first_accel,
	input  logic [63:0]         second_accel,
	input  logic [63:0]         first_position,
	input  logic [63:0]         second_position,
	input  logic [IM_W-1:0]     first_inv_mass,
	input  logic [IM_W-1:0]     second_inv_mass,
	input  logic signed [31:0]  penetration,
	input  logic                has_second,
	input  logic [BOUNCE_W-1:0] bounce,
	output logic                empty,
	input  logic                pop,
	output logic [63:0]         new_first_velocity,
	output logic [63:0]         new_second_velocity,
	output logic [63:0]         new_first_position,
	output logic [63:0]         new_second_position
);

	logic [TS_W-1:0] time_step_q;
	contact_t        ct;
	job_t            job_in;
	job_t            job_out;
	logic            mid_push;
	logic            mid_pop;
	q_stat_t         mid_stat;
	result_t         res_in;
	result_t         res_out;
	logic            out_push;
	logic            out_pop;
	q_stat_t         out_stat;

	// time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TS_RESET;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	// incoming item
	always_comb begin
		ct.n      = vec_t'(contact_normal);
		ct.v0     = vec_t'(first_velocity);
		ct.v1     = vec_t'(second_velocity);
		ct.a0     = vec_t'(first_accel);
		ct.a1     = vec_t'(second_accel);
		ct.p0     = vec_t'(first_position);
		ct.p1     = vec_t'(second_position);
		ct.im0    = first_inv_mass;
		ct.im1    = second_inv_mass;
		ct.pen    = penetration;
		ct.two    = has_second;
		ct.bounce = bounce;
	end

	pcr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.time_step (time_step_q),
		.push      (push),
		.ct        (ct),
		.mid_stat  (mid_stat),
		.job_push  (mid_push),
		.job       (job_in)
	);

	pcr_fifo #(.W($bits(job_t))) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (job_in),
		.rd     (mid_pop),
		.rdata  (job_out),
		.stat   (mid_stat)
	);

	pcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.mid_stat (mid_stat),
		.mid_pop  (mid_pop),
		.out_stat (out_stat),
		.res_push (out_push),
		.res      (res_in)
	);

	assign out_pop = pop && !out_stat.empty;

	pcr_fifo #(.W($bits(result_t))) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (res_in),
		.rd     (out_pop),
		.rdata  (res_out),
		.stat   (out_stat)
	);

	// ports
	assign full                = mid_stat.full;
	assign empty               = out_stat.empty;
	assign new_first_velocity  = res_out.v0;
	assign new_second_velocity = res_out.v1;
	assign new_first_position  = res_out.p0;
	assign new_second_position = res_out.p1;

`ifndef SYNTH
	// front never writes a full middle queue
	a_mid_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_stat.full)
		else $error("middle queue written while full");

	// back never writes a full output queue
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_stat.full)
		else $error("output queue written while full");

	// a result written without a pop is visible next cycle
	a_out_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !out_pop) |=> !out_stat.empty)
		else $error("written result not visible");

	// full only rises after a write into the middle queue
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mid_stat.full) |-> $past(mid_push))
		else $error("full rose without a write");
`endif

endmodule

`default_nettype wire

// File: dv/tb_particle_contact_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_contact_resolver
// Self-checking bench for the contact resolver. Contacts are pushed through
// the input queue port, and each one is predicted in the bench at push time.
// Results are popped and compared against the oldest prediction. The run
// covers a directed set of corner contacts, then random contacts over several
// time step settings with random push gaps and pop stalls.
// ----------------------------------------------------------------------------
`default_nettype none

// predicts resolved contacts and checks popped results in order
class contact_ledger;
	localparam int FB = 16;
	pcr_pkg::result_t pending[$];
	int errors = 0;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor rounding, since >>> on a signed value rounds toward minus infinity
	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	function automatic longint dot(longint ax, longint ay, longint bx, longint by);
		return clip32(qmul(ax, bx) + qmul(ay, by));
	endfunction

	function automatic longint share(longint num, longint total);
		longint unsigned q;
		q = (longint'(num) << FB) / longint'(total);
		return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
	endfunction

	// note one accepted contact under the current time step
	function void note(pcr_pkg::contact_t c, logic [pcr_pkg::TS_W-1:0] ts);
		pcr_pkg::result_t r;
		longint nx, ny, v0x, v0y, v1x, v1y, a0x, a0y, a1x, a1y;
		longint p0x, p0y, p1x, p1y, im0, im1, pen, bnc, total, dt;
		longint o0x, o0y, o1x, o1y, q0x, q0y, q1x, q1y;
		longint rvx, rvy, sep, rax, ray, acc, acc_sep, target, dv, imp, ix, iy;
		longint mv, mx, my;
		nx = c.n.x;   ny = c.n.y;
		v0x = c.v0.x; v0y = c.v0.y; v1x = c.v1.x; v1y = c.v1.y;
		a0x = c.a0.x; a0y = c.a0.y; a1x = c.a1.x; a1y = c.a1.y;
		p0x = c.p0.x; p0y = c.p0.y; p1x = c.p1.x; p1y = c.p1.y;
		im0 = c.im0;
		im1 = c.two ? longint'(c.im1) : 0;
		pen = c.pen;
		bnc = c.bounce;
		dt = ts;
		total = im0 + im1;
		o0x = v0x; o0y = v0y; o1x = v1x; o1y = v1y;
		q0x = p0x; q0y = p0y; q1x = p1x; q1y = p1y;
		// zero total inverse mass leaves everything alone
		if (total != 0) begin
			rvx = c.two ? clip32(v0x - v1x) : v0x;
			rvy = c.two ? clip32(v0y - v1y) : v0y;
			sep = dot(rvx, rvy, nx, ny);
			// closing contacts only
			if (sep <= 0) begin
				rax = c.two ? clip32(a0x - a1x) : a0x;
				ray = c.two ? clip32(a0y - a1y) : a0y;
				acc = dot(rax, ray, nx, ny);
				acc_sep = clip32(qmul(acc, dt));
				target = clip32(qmul(-sep, bnc));
				if (acc_sep < 0) begin
					target += qmul(bnc, acc_sep);
					if (target < 0) target = 0;
				end
				dv = target - sep;
				imp = share(dv, total);
				ix = clip32(qmul(nx, imp));
				iy = clip32(qmul(ny, imp));
				o0x = clip32(v0x + qmul(ix, im0));
				o0y = clip32(v0y + qmul(iy, im0));
				if (c.two) begin
					o1x = clip32(v1x - qmul(ix, im1));
					o1y = clip32(v1y - qmul(iy, im1));
				end
			end
			// push apart along the normal
			if (pen > 0) begin
				mv = share(pen, total);
				mx = clip32(qmul(nx, mv));
				my = clip32(qmul(ny, mv));
				q0x = clip32(p0x + qmul(mx, im0));
				q0y = clip32(p0y + qmul(my, im0));
				if (c.two) begin
					q1x = clip32(p1x - qmul(mx, im1));
					q1y = clip32(p1y - qmul(my, im1));
				end
			end
		end
		r.v0.x = o0x[31:0]; r.v0.y = o0y[31:0];
		r.v1.x = o1x[31:0]; r.v1.y = o1y[31:0];
		r.p0.x = q0x[31:0]; r.p0.y = q0y[31:0];
		r.p1.x = q1x[31:0]; r.p1.y = q1y[31:0];
		pending.push_back(r);
	endfunction

	function void mismatch(string fld, logic [63:0] exp_v, logic [63:0] act_v);
		errors++;
		$display("%0t %s mismatch: expected %h actual %h", $time, fld, exp_v, act_v);
	endfunction

	// check one popped result against the oldest prediction
	function void check(pcr_pkg::result_t got);
		pcr_pkg::result_t e;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t unexpected result: expected none actual %h", $time, got);
			return;
		end
		e = pending.pop_front();
		if (got.v0 !== e.v0) mismatch("new_first_velocity", e.v0, got.v0);
		if (got.v1 !== e.v1) mismatch("new_second_velocity", e.v1, got.v1);
		if (got.p0 !== e.p0) mismatch("new_first_position", e.p0, got.p0);
		if (got.p1 !== e.p1) mismatch("new_second_position", e.p1, got.p1);
	endfunction
endclass

module tb_particle_contact_resolver;
	import pcr_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [TS_W-1:0]     cfg_wdata = '0;
	logic                push = 1'b0;
	logic                full;
	logic [63:0]         contact_normal = '0;
	logic [63:0]         first_velocity = '0;
	logic [63:0]         second_velocity = '0;
	logic [63:0]         first_accel = '0;
	logic [63:0]         second_accel = '0;
	logic [63:0]         first_position = '0;
	logic [63:0]         second_position = '0;
	logic [IM_W-1:0]     first_inv_mass = '0;
	logic [IM_W-1:0]     second_inv_mass = '0;
	logic signed [31:0]  penetration = '0;
	logic                has_second = 1'b0;
	logic [BOUNCE_W-1:0] bounce = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [63:0]         new_first_velocity;
	logic [63:0]         new_second_velocity;
	logic [63:0]         new_first_position;
	logic [63:0]         new_second_position;

	contact_ledger   ledger = new();
	logic [TS_W-1:0] cur_ts = TS_RESET;
	int              gap_pct = 0;
	int              stall_pct = 0;
	bit              running = 1'b0;

	particle_contact_resolver #(.FRAC_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full),
		.contact_normal(contact_normal),
		.first_velocity(first_velocity), .second_velocity(second_velocity),
		.first_accel(first_accel), .second_accel(second_accel),
		.first_position(first_position), .second_position(second_position),
		.first_inv_mass(first_inv_mass), .second_inv_mass(second_inv_mass),
		.penetration(penetration), .has_second(has_second), .bounce(bounce),
		.empty(empty), .pop(pop),
		.new_first_velocity(new_first_velocity),
		.new_second_velocity(new_second_velocity),
		.new_first_position(new_first_position),
		.new_second_position(new_second_position)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#20ms;
		$display("tb_particle_contact_resolver: errors");
		$finish;
	end

	// receiver: check on each pop, stall at random
	always @(posedge clk) begin
		if (running) begin
			if (pop && !empty)
				ledger.check({new_first_velocity, new_second_velocity,
					new_first_position, new_second_position});
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	// push one contact, with a random gap ahead of it
	task automatic send(contact_t c);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push            <= 1'b1;
		contact_normal  <= c.n;
		first_velocity  <= c.v0;
		second_velocity <= c.v1;
		first_accel     <= c.a0;
		second_accel    <= c.a1;
		first_position  <= c.p0;
		second_position <= c.p1;
		first_inv_mass  <= c.im0;
		second_inv_mass <= c.im1;
		penetration     <= c.pen;
		has_second      <= c.two;
		bounce          <= c.bounce;
		do @(posedge clk); while (full);
		ledger.note(c, cur_ts);
	endtask

	// drain, let the pipe settle, then load a new time step
	task automatic set_step(logic [TS_W-1:0] ts);
		push <= 1'b0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ts;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_ts = ts;
	endtask

	function automatic logic [31:0] moderate();
		case ($urandom_range(3))
			0: return 32'($signed($urandom_range(131072)) - 65536);
			1: return 32'($signed($urandom_range(2097152)) - 1048576);
			2: return $urandom();
			default: return 32'($signed($urandom_range(512)) - 256) << 12;
		endcase
	endfunction

	function automatic logic [31:0] unit_axis();
		case ($urandom_range(4))
			0: return 32'h0001_0000;
			1: return 32'hFFFF_0000;
			2: return 32'h0000_B505;
			3: return 32'hFFFF_4AFB;
			default: return 32'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	// mostly plausible contacts, some fully random noise
	function automatic contact_t random_contact();
		contact_t     c;
		logic [575:0] raw;
		if ($urandom_range(99) < 20) begin
			raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()};
			c = raw[$bits(contact_t)-1:0];
			return c;
		end
		c.n.x  = unit_axis();  c.n.y  = unit_axis();
		c.v0.x = moderate();   c.v0.y = moderate();
		c.v1.x = moderate();   c.v1.y = moderate();
		c.a0.x = moderate();   c.a0.y = moderate();
		c.a1.x = moderate();   c.a1.y = moderate();
		c.p0.x = moderate();   c.p0.y = moderate();
		c.p1.x = moderate();   c.p1.y = moderate();
		c.im0 = ($urandom_range(9) == 0) ? '0 : IM_W'($urandom_range(262144));
		c.im1 = ($urandom_range(9) == 0) ? '0 : IM_W'($urandom_range(262144));
		c.pen = ($urandom_range(2) == 0) ? moderate() : 32'($urandom_range(65536));
		c.two = 1'($urandom_range(1));
		c.bounce = ($urandom_range(19) == 0) ? BOUNCE_W'($urandom())
			: BOUNCE_W'($urandom_range(65536));
		return c;
	endfunction

	initial begin
		contact_t c;
		logic [TS_W-1:0] steps[4];
		steps = '{21'd0, 21'h1F_FFFF, 21'd1048576, 21'd1092};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// directed corners under the reset time step
		c = '0;                              send(c);   // all zero, no mass
		c = '1;                              send(c);   // all ones
		c = '0; c.n.x = 32'h0001_0000; c.v0.x = 32'hFFFE_0000; c.im0 = 31'h1_0000;
		c.bounce = 17'h1_0000; c.pen = 32'h0000_8000;
		send(c);                                        // fixed obstacle hit
		c.two = 1'b1; c.im1 = 31'h1_0000; c.v1.x = 32'h0003_0000;
		send(c);                                        // closing pair
		c.v1.x = 32'hFFFD_0000; c.bounce = '0; c.pen = 32'hFFFF_0000;
		send(c);                                        // separating, no bounce
		c.bounce = '1; c.pen = 32'h7FFF_FFFF;  send(c); // over-range bounce
		c.a0.x = 32'h8000_0000; c.bounce = 17'h1_0000;
		send(c);                                        // strong accel along normal
		c.im0 = '1; c.im1 = '1;               send(c); // max inverse masses
		c.n = {32'h8000_0000, 32'h8000_0000};
		c.v0 = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
		c.v1 = {32'h8000_0000, 32'h8000_0000};
		send(c);                                        // saturating relatives
		c.im0 = '0; c.im1 = '0;               send(c); // zero total mass, pair
		c.im0 = '0; c.im1 = 31'h1_0000; c.two = 1'b0;
		send(c);                                        // second mass ignored
		c.im0 = 31'd1; c.pen = 32'd1; c.v0 = '0; c.v1 = '0;
		send(c);                                        // tiny mass, tiny depth
		c.pen = '0;                           send(c); // zero depth

		// random phases over several time steps and idling mixes
		for (int ph = 0; ph < 4; ph++) begin
			set_step(ph == 3 ? TS_W'($urandom()) : steps[ph]);
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 71; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 71; end
				default: begin gap_pct = 9; stall_pct = 9; end
			endcase
			for (int i = 0; i < 350; i++) send(random_contact());
		end
		set_step(steps[3]);

		repeat (60) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending.size() == 0)
			$display("tb_particle_contact_resolver: clean");
		else
			$display("tb_particle_contact_resolver: errors");
		$finish;
	end

endmodule

`default_nettype wire

// File: particle_contact_resolver.f
hdl/pcr_pkg.sv
hdl/pcr_fifo.sv
hdl/pcr_front.sv
hdl/pcr_div.sv
hdl/pcr_back.sv
hdl/particle_contact_resolver.sv
dv/tb_particle_contact_resolver.sv
